@@ hw/rtl/nwsc_pkg.sv @@
package nwsc_pkg;

  // fixed widths of the configuration and result fields
  localparam int CFG_W   = 63;
  localparam int CNT_W   = 7;
  localparam int TOL_W   = 10;
  localparam int OWNER_W = 20;
  localparam int SHELL_W = 6;
  localparam int IDX_W   = 3;

  // defaults for the top level parameters
  localparam int DEF_MAX_SHELLS = 64;
  localparam int DEF_COORD_BITS = 21;
  localparam int DEF_ID_BITS    = 20;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MIDPOINT    = 3'd0,
    REG_LAYER       = 3'd1,
    REG_CORE        = 3'd2,
    REG_HALF_STEP   = 3'd3,
    REG_SHELL_COUNT = 3'd4,
    REG_TOLERANCE   = 3'd5
  } cfg_reg_t;

endpackage

@@ hw/rtl/nwsc_div.sv @@
module nwsc_div
  import nwsc_pkg::*;
#(
  parameter int DW = DEF_COORD_BITS,
  parameter int QB = CNT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [QB-1:0] num,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QB-1:0] quot
);

  localparam int SW = (QB > 1) ? $clog2(QB) : 1;

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [DW-1:0] rem_r;
  logic [QB-1:0] num_r;
  logic [QB-1:0] q_r;

  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          qbit;
  logic [DW-1:0] rem_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    sh      = {rem_r, num_r[QB-1]};
    diff    = sh - {1'b0, divisor};
    qbit    = (sh >= {1'b0, divisor});
    rem_nxt = qbit ? diff[DW-1:0] : sh[DW-1:0];
  end

  // step sequencer, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= rem_init;
        num_r  <= num;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        num_r  <= {num_r[QB-2:0], 1'b0};
        q_r    <= {q_r[QB-2:0], qbit};
        step_r <= step_r + 1'b1;
        if (step_r == SW'(QB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ hw/rtl/nested_window_shell_classifier_unit.sv @@
// Nested window shell classifier.
// Input channel (in_valid/in_ready): one point per request, three signed
// coordinates and an owner id. Result channel (out_valid/out_ready): the
// shell index, the owner id passed through, and a flag that is set when the
// owner is not the last one recorded for that shell. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and writes one
// register per request; write it only while no point is in flight.
// One point at a time: for each axis the coordinate is mirrored, then the
// axis resolves by compare or runs the shared divider (7 quotient bits, one
// per cycle, plus start and hand-back). The memory read, the update and the
// load of the output register follow. The next point is taken in the cycle
// after the result is loaded. The per-shell owner memory is a single-port
// array. After reset the block sweeps that memory clear, one entry a cycle,
// with in_ready low until the sweep ends; configuration writes are taken
// during the sweep. Configuration and control registers return to their
// reset values. If the receiver stalls, the result waits in the output
// register while one more point is taken and worked; that point's result
// then waits until the register is free.
module nested_window_shell_classifier_unit
  import nwsc_pkg::*;
#(
  parameter int MAX_SHELLS = DEF_MAX_SHELLS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int ID_BITS    = DEF_ID_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  input  logic [OWNER_W-1:0]           in_owner_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SHELL_W-1:0]           out_shell_index,
  output logic [OWNER_W-1:0]           out_owner_out,
  output logic                         out_is_new,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int AW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
  localparam int EW = (CW > TOL_W) ? CW + 3 : TOL_W + 3;
  localparam int QB = CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MIRROR,
    S_CLASS,
    S_DIV,
    S_READ,
    S_UPDATE,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CFG_W-1:0] midpoint_r;
  logic [CFG_W-1:0] layer_r;
  logic [CFG_W-1:0] core_r;
  logic [CFG_W-1:0] half_step_r;
  logic [CNT_W-1:0] count_r;
  logic [TOL_W-1:0] tol_r;

  // point in flight
  logic signed [CW-1:0] coord_r [3];
  logic [OWNER_W-1:0]   owner_r;
  logic [CNT_W-1:0]     top_r;
  logic [1:0]           axis_r;
  logic signed [EW-1:0] c_r;
  logic [CNT_W-1:0]     min_r;
  logic [AW-1:0]        clr_r;
  logic [ID_BITS:0]     rd_r;

  // result register
  logic [SHELL_W-1:0] shell_r;
  logic [OWNER_W-1:0] owner_out_r;
  logic               is_new_r;
  logic               out_valid_r;
  logic               out_load;

  // per shell seen mark (top bit) and last owner
  logic [ID_BITS:0] mem [MAX_SHELLS];

  // lane select for the current axis
  logic signed [CW-1:0] m_s, l_s, k_s;
  logic [CW-1:0]        h_s;
  logic signed [EW-1:0] cin_ext, m_ext, l_ext, k_ext, t_ext;
  logic signed [EW-1:0] mir, d, n;
  logic [EW-1:0]        n_u, hi_u, h_ext;
  logic                 below, above, h_zero, sat;

  always_comb begin
    m_s     = midpoint_r[axis_r*CW +: CW];
    l_s     = layer_r[axis_r*CW +: CW];
    k_s     = core_r[axis_r*CW +: CW];
    h_s     = half_step_r[axis_r*CW +: CW];
    cin_ext = EW'(coord_r[axis_r]);
    m_ext   = EW'(m_s);
    l_ext   = EW'(l_s);
    k_ext   = EW'(k_s);
    t_ext   = $signed(EW'(tol_r));
    h_ext   = EW'(h_s);
    // mirror about the midpoint
    mir     = (cin_ext > m_ext) ? (m_ext + m_ext - cin_ext) : cin_ext;
    // boundary, core and saturation checks on the mirrored coordinate
    d       = c_r - l_ext;
    n       = d + t_ext;
    n_u     = n;
    hi_u    = n_u >> QB;
    below   = (c_r < l_ext) || (d < t_ext);
    above   = (c_r > k_ext);
    h_zero  = (h_s == '0);
    sat     = (hi_u >= h_ext);
  end

  // shared divider, only the low quotient bits below saturation
  logic          div_start;
  logic          div_done;
  logic [QB-1:0] div_quot;

  assign div_start = (state_r == S_CLASS) && !below && !above && !h_zero && !sat;

  nwsc_div #(
    .DW (CW),
    .QB (QB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (hi_u[CW-1:0]),
    .num      (n_u[QB-1:0]),
    .divisor  (h_s),
    .done     (div_done),
    .quot     (div_quot)
  );

  // per axis shell and running minimum
  logic             axis_done;
  logic [CNT_W-1:0] axis_val;
  logic [CNT_W-1:0] min_nxt;

  always_comb begin
    axis_done = 1'b0;
    axis_val  = top_r;
    if (state_r == S_CLASS) begin
      axis_done = !div_start;
      axis_val  = below ? '0 : top_r;
    end else if (state_r == S_DIV && div_done) begin
      axis_done = 1'b1;
      axis_val  = (div_quot >= top_r) ? top_r : div_quot + 1'b1;
    end
    min_nxt = (axis_r == 2'd0 || axis_val < min_r) ? axis_val : min_r;
  end

  // shell count clamp
  logic [CNT_W-1:0] cnt_c;

  always_comb begin
    if (count_r < CNT_W'(2)) begin
      cnt_c = CNT_W'(2);
    end else if (int'(count_r) > MAX_SHELLS) begin
      cnt_c = CNT_W'(MAX_SHELLS);
    end else begin
      cnt_c = count_r;
    end
  end

  // memory access
  logic [AW-1:0]    idx;
  logic             fresh;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ID_BITS:0] mem_wdata;
  logic [ID_BITS-1:0] owner_key;

  always_comb begin
    idx       = AW'(min_r);
    owner_key = ID_BITS'(owner_r);
    fresh     = !rd_r[ID_BITS] || (rd_r[ID_BITS-1:0] != owner_key);
    mem_we    = (state_r == S_CLEAR) || (state_r == S_UPDATE && fresh);
    mem_waddr = (state_r == S_CLEAR) ? clr_r : idx;
    mem_wdata = (state_r == S_CLEAR) ? '0 : {1'b1, owner_key};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_READ) begin
      rd_r <= mem[idx];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      midpoint_r  <= '0;
      layer_r     <= '0;
      core_r      <= '0;
      half_step_r <= '0;
      count_r     <= CNT_W'(2);
      tol_r       <= TOL_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIDPOINT:    midpoint_r  <= cfg_data;
        REG_LAYER:       layer_r     <= cfg_data;
        REG_CORE:        core_r      <= cfg_data;
        REG_HALF_STEP:   half_step_r <= cfg_data;
        REG_SHELL_COUNT: count_r     <= cfg_data[CNT_W-1:0];
        REG_TOLERANCE:   tol_r       <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // output register takes a result when empty or being drained
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        shell_r     <= min_r[SHELL_W-1:0];
        owner_out_r <= owner_r;
        is_new_r    <= fresh;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_SHELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            coord_r[0] <= in_coord_x;
            coord_r[1] <= in_coord_y;
            coord_r[2] <= in_coord_z;
            owner_r    <= in_owner_id;
            top_r      <= cnt_c - 1'b1;
            axis_r     <= '0;
            state_r    <= S_MIRROR;
          end
        end
        S_MIRROR: begin
          c_r     <= mir;
          state_r <= S_CLASS;
        end
        S_CLASS, S_DIV: begin
          if (div_start) begin
            state_r <= S_DIV;
          end else if (axis_done) begin
            min_r <= min_nxt;
            if (axis_r == 2'd2) begin
              state_r <= S_READ;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_MIRROR;
            end
          end
        end
        S_READ: begin
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_shell_index = shell_r;
  assign out_owner_out   = owner_out_r;
  assign out_is_new      = is_new_r;
  assign cfg_ready       = 1'b1;

endmodule

@@ verif/nested_window_shell_classifier_unit_test.sv @@
`timescale 1ns / 1ps

module nested_window_shell_classifier_unit_test;
  import nwsc_pkg::*;

  localparam int CW     = DEF_COORD_BITS;
  localparam int SHELLS = DEF_MAX_SHELLS;
  localparam int SETTLE = 40;
  localparam longint CMIN = -(longint'(1) << (CW - 1));
  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;

  // one predicted result
  typedef struct packed {
    logic [SHELL_W-1:0] shell;
    logic [OWNER_W-1:0] owner;
    logic               fresh;
  } shell_result_t;

  // predicts the shell of each point and tracks the per-shell owner memory
  class shell_scoreboard;
    bit [CFG_W-1:0] mid_r, lay_r, cor_r, hs_r;
    bit [CNT_W-1:0] count_r;
    bit [TOL_W-1:0] tol_r;
    bit             seen[SHELLS];
    bit [OWNER_W-1:0] last_owner[SHELLS];
    shell_result_t  pending_q[$];
    int             errors;

    function new();
      mid_r = '0;
      lay_r = '0;
      cor_r = '0;
      hs_r = '0;
      count_r = 2;
      tol_r = 1;
      errors = 0;
      foreach (seen[i]) seen[i] = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [CFG_W-1:0] d);
      case (idx)
        REG_MIDPOINT:    mid_r = d;
        REG_LAYER:       lay_r = d;
        REG_CORE:        cor_r = d;
        REG_HALF_STEP:   hs_r = d;
        REG_SHELL_COUNT: count_r = d[CNT_W-1:0];
        REG_TOLERANCE:   tol_r = d[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function longint lane_value(bit [CFG_W-1:0] r, int i, bit sgn);
      bit [CW-1:0] v;
      v = r[i*CW +: CW];
      if (sgn) return longint'($signed(v));
      return longint'(v);
    endfunction

    // per-axis shell: mirror about the midpoint, then layer, core, divide
    function int unsigned axis_shell(longint c, int i, int unsigned top);
      longint m, l, k, h, t, d, q;
      m = lane_value(mid_r, i, 1'b1);
      l = lane_value(lay_r, i, 1'b1);
      k = lane_value(cor_r, i, 1'b1);
      h = lane_value(hs_r, i, 1'b0);
      t = longint'(tol_r);
      if (c > m) c = 2 * m - c;
      if (c < l) return 0;
      d = c - l;
      if (d < t) return 0;
      if (c > k) return top;
      if (h == 0) return top;
      q = (d + t) / h;
      if (q >= top) return top;
      return int'(q) + 1;
    endfunction

    function void note_point(logic signed [CW-1:0] x, y, z, logic [OWNER_W-1:0] id);
      int unsigned cnt, top, s, sy, sz;
      shell_result_t r;
      cnt = count_r;
      if (cnt < 2) cnt = 2;
      if (cnt > SHELLS) cnt = SHELLS;
      top = cnt - 1;
      s = axis_shell(longint'(x), 0, top);
      sy = axis_shell(longint'(y), 1, top);
      sz = axis_shell(longint'(z), 2, top);
      if (sy < s) s = sy;
      if (sz < s) s = sz;
      r.shell = s[SHELL_W-1:0];
      r.owner = id;
      r.fresh = !seen[s] || last_owner[s] != id;
      if (r.fresh) begin
        seen[s] = 1'b1;
        last_owner[s] = id;
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(logic [SHELL_W-1:0] shell, logic [OWNER_W-1:0] owner,
                               logic fresh);
      shell_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding: shell %0d owner %0h", shell, owner);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (shell !== e.shell) begin
        $error("shell_index mismatch: expected %0d, got %0d", e.shell, shell);
        errors++;
      end
      if (owner !== e.owner) begin
        $error("owner_out mismatch: expected %0h, got %0h", e.owner, owner);
        errors++;
      end
      if (fresh !== e.fresh) begin
        $error("is_new mismatch: expected %0b, got %0b", e.fresh, fresh);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [CW-1:0]  in_coord_x = '0;
  logic signed [CW-1:0]  in_coord_y = '0;
  logic signed [CW-1:0]  in_coord_z = '0;
  logic [OWNER_W-1:0]    in_owner_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SHELL_W-1:0]    out_shell_index;
  logic [OWNER_W-1:0]    out_owner_out;
  logic                  out_is_new;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = REG_MIDPOINT;
  logic [CFG_W-1:0]      cfg_data = '0;

  shell_scoreboard sb = new();

  // window geometry on the stimulus side
  longint geo_mid[3], geo_lay[3], geo_cor[3], geo_hs[3];
  int     geo_cnt, geo_tol;
  logic [OWNER_W-1:0] owner_pool[4];

  // receiver state
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int          results_seen = 0;
  bit          held_once = 1'b0;

  nested_window_shell_classifier_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_owner_id     (in_owner_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_shell_index (out_shell_index),
    .out_owner_out   (out_owner_out),
    .out_is_new      (out_is_new),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint rnd(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic bit [CFG_W-1:0] pack_lanes(longint a0, longint a1, longint a2);
    return {a2[CW-1:0], a1[CW-1:0], a0[CW-1:0]};
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    if ($urandom_range(9) < 7) return owner_pool[$urandom_range(3)];
    return OWNER_W'($urandom);
  endfunction

  // one register write request; valid stays up for the next one
  task automatic write_reg(cfg_reg_t idx, bit [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_settings();
    write_reg(REG_MIDPOINT, pack_lanes(geo_mid[0], geo_mid[1], geo_mid[2]));
    write_reg(REG_LAYER, pack_lanes(geo_lay[0], geo_lay[1], geo_lay[2]));
    write_reg(REG_CORE, pack_lanes(geo_cor[0], geo_cor[1], geo_cor[2]));
    write_reg(REG_HALF_STEP, pack_lanes(geo_hs[0], geo_hs[1], geo_hs[2]));
    write_reg(REG_SHELL_COUNT, CFG_W'(geo_cnt));
    write_reg(REG_TOLERANCE, CFG_W'(geo_tol));
    cfg_valid <= 1'b0;
  endtask

  // fixed window used by the directed points
  task automatic fixed_window();
    for (int i = 0; i < 3; i++) begin
      geo_mid[i] = 400000;
      geo_lay[i] = -300000;
      geo_cor[i] = 300000;
      geo_hs[i] = 60000;
    end
    geo_cnt = 10;
    geo_tol = 5;
  endtask

  // random nested window per axis, half step sized to the shell count
  task automatic random_window(int cnt, int tol);
    longint span, ec;
    geo_cnt = cnt;
    geo_tol = tol;
    ec = (cnt < 2) ? 2 : (cnt > SHELLS) ? SHELLS : cnt;
    for (int i = 0; i < 3; i++) begin
      geo_mid[i] = rnd(-500000, 1000000);
      span = rnd(1000, 1200000);
      geo_lay[i] = clamp_coord(geo_mid[i] - span - rnd(0, 50000));
      geo_cor[i] = clamp_coord(geo_lay[i] + span * rnd(50, 100) / 100);
      geo_hs[i] = span / ec * rnd(50, 200) / 100;
      if (geo_hs[i] < 1) geo_hs[i] = 1;
      case ($urandom_range(11))
        0: geo_hs[i] = 0;
        1: geo_hs[i] = rnd(0, 2097151);
        default: ;
      endcase
    end
  endtask

  // point inside the window at a common depth, near an edge, or anywhere
  task automatic gen_point(output longint x, y, z);
    longint c[3];
    longint f, m, l, k, t;
    int mode;
    mode = $urandom_range(9);
    f = rnd(0, 1100);
    t = geo_tol;
    for (int i = 0; i < 3; i++) begin
      m = geo_mid[i];
      l = geo_lay[i];
      k = geo_cor[i];
      if (mode < 6) begin
        c[i] = l + (k - l) * f / 1000 + rnd(-20, 20);
        if ($urandom_range(1) == 1) c[i] = 2 * m - c[i];
      end else if (mode < 8) begin
        case ($urandom_range(8))
          0: c[i] = l;
          1: c[i] = l + t - 1;
          2: c[i] = l + t;
          3: c[i] = l - 1;
          4: c[i] = k;
          5: c[i] = k + 1;
          6: c[i] = m;
          7: c[i] = m + 1;
          default: c[i] = 2 * m - l;
        endcase
      end else begin
        c[i] = rnd(CMIN, CMAX);
      end
      c[i] = clamp_coord(c[i]);
    end
    x = c[0];
    y = c[1];
    z = c[2];
  endtask

  // one point request; valid stays up for a following point
  task automatic push_point(input longint x, y, z,
                            input logic [OWNER_W-1:0] id);
    in_valid <= 1'b1;
    in_coord_x <= CW'(x);
    in_coord_y <= CW'(y);
    in_coord_z <= CW'(z);
    in_owner_id <= id;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_point(CW'(x), CW'(y), CW'(z), id);
  endtask

  // bursts of random length with random gaps
  task automatic run_points(int n);
    int sent, burst;
    longint x, y, z;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < n; b++) begin
        gen_point(x, y, z);
        push_point(x, y, z, pick_owner());
        sent++;
      end
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  // drain all results, then let the block settle before reconfiguring
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver: checks results and stalls on a rotating pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_shell_index, out_owner_out, out_is_new);
      results_seen++;
    end
    rx_cycle++;
    // one long hold-off so the block backs up into the input
    if (!held_once && results_seen >= 200) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 600) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(1) == 1);
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < 4; i++) owner_pool[i] = OWNER_W'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: everything lands in the boundary layer
    push_point(0, 0, 0, 20'h00000);
    push_point(0, 0, 0, 20'h00000);
    push_point(CMAX, CMIN, CMAX, 20'hFFFFF);
    push_point(CMIN, CMAX, CMIN, 20'h00001);
    push_point(1, -1, 0, 20'hFFFFF);
    finish_phase();

    // fixed window: edges of the layer band, core, mirror, extremes
    fixed_window();
    apply_settings();
    push_point(CMIN, 300000, 300000, 20'h00010);
    push_point(-300000, 300000, 300000, 20'h00010);
    push_point(-299996, 300000, 300000, 20'h00011);
    push_point(-299995, 300000, 300000, 20'h00012);
    push_point(0, 300000, 300000, 20'h00013);
    push_point(300000, 300000, 300000, 20'h00014);
    push_point(300001, 300000, 300000, 20'h00014);
    push_point(CMAX, 300000, 300000, 20'h00015);
    push_point(800000, 300000, 300000, 20'h00016);
    push_point(800000, 300000, 300000, 20'h00016);
    push_point(0, 300000, 300000, 20'hFFFFF);
    push_point(300000, CMIN, 300000, 20'h00000);
    push_point(300000, 300000, -300000, 20'h00000);
    finish_phase();

    // zero half step on x, shell count below range, zero tolerance
    geo_hs[0] = 0;
    geo_cnt = 1;
    geo_tol = 0;
    apply_settings();
    push_point(-300000, 300000, 300000, 20'h00020);
    push_point(-300001, 300000, 300000, 20'h00021);
    push_point(0, 300000, 300000, 20'h00022);
    push_point(300000, -300000, 300000, 20'h00023);
    finish_phase();

    // random phases over a range of settings, extremes included
    for (int p = 0; p < 11; p++) begin
      case (p)
        0: random_window(SHELLS, 0);
        1: random_window(127, 1023);
        2: random_window(0, int'(rnd(0, 1023)));
        3: random_window(1, 3);
        4: begin
          random_window(int'(rnd(2, 64)), int'(rnd(0, 1023)));
          geo_hs[0] = 0;
          geo_hs[1] = 2097151;
        end
        5: begin
          random_window(33, 2);
          geo_mid[0] = CMAX;
          geo_lay[0] = CMIN;
          geo_cor[0] = CMAX;
        end
        6: random_window(int'(rnd(65, 126)), int'(rnd(0, 1023)));
        10: begin
          random_window(int'(rnd(2, 64)), int'(rnd(0, 1023)));
          geo_mid[2] = CMIN;
        end
        default: random_window(int'(rnd(2, 64)), int'(rnd(0, 1023)));
      endcase
      apply_settings();
      run_points(p == 10 ? 20 : 145);
      finish_phase();
    end

    if (sb.errors == 0) begin
      $display("nested_window_shell_classifier_unit test passed");
    end else begin
      $display("nested_window_shell_classifier_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("nested_window_shell_classifier_unit test failed");
    $finish;
  end

endmodule
